// ===== hw/rtl/tcs_pkg.sv =====
// Shared types, constants and helpers for the text console cursor/scroll engine.
// Depends on nothing; imported by tcs_ctrl, the top level and the testbench.
package tcs_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ADDR_W    = ROW_W + COL_W;
    // Each row occupies a power-of-two stride so the address is {row, col}
    localparam int MEM_DEPTH = ROWS * (1 << COL_W);
    localparam int CELL_W    = 16;

    // Character and attribute codes
    localparam logic [7:0]        NEWLINE_CODE = 8'd10;
    localparam logic [7:0]        BLANK_CODE   = 8'h20;
    localparam logic [7:0]        ERROR_ATTR   = 8'h04;
    localparam logic [7:0]        RESET_COLOR  = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

    // Request and result kinds
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_READ    = 1'b1;
    localparam logic KIND_ECHO   = 1'b0;
    localparam logic KIND_CELL   = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic       error_style;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  serial_byte;
        logic [15:0] cell_word;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        last;
    } res_t;

    // Cell store access from the controller
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // Map a logical row onto the rotating physical row base
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS))
            sum = sum - (ROW_W+1)'(ROWS);
        return sum[ROW_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/tcs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/tcs_ctrl.sv =====
// Request sequencer: cursor, rotating row base, clearing sweeps and result register.
// Depends on tcs_pkg; drives the cell store through a mem_req_t bundle.
module tcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tcs_pkg::req_t     req,
    input  logic [7:0]        text_color,
    output tcs_pkg::mem_req_t mem,
    input  logic [15:0]       rd_data,
    output logic              result_valid,
    output tcs_pkg::res_t     result
);
    import tcs_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_ECHO_NL
    } state_t;

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [ROW_W-1:0]   clr_row_reg, clr_row_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]         attr_reg, attr_next;
    logic               inrange_reg, inrange_next;
    logic               result_valid_reg, result_valid_next;
    res_t               result_reg, result_next;

    logic               accept;
    logic [7:0]         attr;
    logic               is_nl;
    logic               wrap;
    logic               line_adv;

    function automatic res_t make_res(input logic kind, input logic [7:0] byte_v,
                                      input logic [15:0] cell_v, input logic lst,
                                      input logic [ROW_W-1:0] r,
                                      input logic [COL_W-1:0] c);
        res_t res;
        res.result_kind = kind;
        res.serial_byte = byte_v;
        res.cell_word   = cell_v;
        res.cursor_row  = 5'(r);
        res.cursor_col  = 7'(c);
        res.last        = lst;
        return res;
    endfunction

    assign accept       = start && (state_reg == ST_IDLE);
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Next-state and store access
    always_comb
    begin
        state_next        = state_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        top_next          = top_reg;
        clr_row_next      = clr_row_reg;
        cnt_next          = cnt_reg;
        attr_next         = attr_reg;
        inrange_next      = inrange_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        mem               = '0;
        attr              = req.error_style ? ERROR_ATTR : text_color;
        is_nl             = (req.char_code == NEWLINE_CODE);
        wrap              = (({1'b0, col_reg} + (COL_W+1)'(1)) == (COL_W+1)'(COLUMNS));
        line_adv          = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                // Sweep the whole store to blank grey
                mem.wr_en   = 1'b1;
                mem.wr_addr = cnt_reg;
                mem.wr_data = RESET_CELL;
                if (cnt_reg == ADDR_W'(MEM_DEPTH - 1))
                    state_next = ST_IDLE;
                else
                    cnt_next = cnt_reg + ADDR_W'(1);
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    attr_next = attr;
                    if (req.req_type == REQ_READ)
                    begin
                        // Issue the cell read
                        mem.rd_en    = 1'b1;
                        mem.rd_addr  = {phys_row(ROW_W'(req.read_row), top_reg),
                                        COL_W'(req.read_col)};
                        inrange_next = ({3'b0, req.read_row} < 8'(ROWS)) &&
                                       ({2'b0, req.read_col} < 9'(COLUMNS));
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        if (!is_nl)
                        begin
                            // Store the character at the cursor
                            mem.wr_en   = 1'b1;
                            mem.wr_addr = {phys_row(row_reg, top_reg), col_reg};
                            mem.wr_data = {attr, req.char_code};
                            if (!wrap)
                                col_next = col_reg + COL_W'(1);
                        end
                        line_adv = is_nl || wrap;

                        // Advance to the next line, scrolling from the bottom row
                        if (line_adv)
                        begin
                            col_next = '0;
                            if (row_reg == ROW_W'(ROWS - 1))
                            begin
                                top_next     = (top_reg == ROW_W'(ROWS - 1)) ?
                                               '0 : top_reg + ROW_W'(1);
                                clr_row_next = top_reg;
                                cnt_next     = '0;
                                state_next   = ST_CLEAR;
                            end
                            else
                            begin
                                row_next = row_reg + ROW_W'(1);
                                if (wrap && !is_nl)
                                    state_next = ST_ECHO_NL;
                            end
                        end

                        // Echo now unless a newline waits for the row clear
                        if (!is_nl)
                        begin
                            result_valid_next = 1'b1;
                            result_next = make_res(KIND_ECHO, req.char_code, 16'h0,
                                                   !line_adv, row_next, col_next);
                        end
                        else if (state_next == ST_IDLE)
                        begin
                            result_valid_next = 1'b1;
                            result_next = make_res(KIND_ECHO, NEWLINE_CODE, 16'h0,
                                                   1'b1, row_next, col_next);
                        end
                    end
                end
            end

            ST_READ:
            begin
                // Return the cell, zero when out of range
                result_valid_next = 1'b1;
                result_next = make_res(KIND_CELL, 8'h00,
                                       inrange_reg ? rd_data : 16'h0000,
                                       1'b1, row_reg, col_reg);
                state_next = ST_IDLE;
            end

            ST_CLEAR:
            begin
                // Blank the row that has become the bottom line
                mem.wr_en   = 1'b1;
                mem.wr_addr = {clr_row_reg, cnt_reg[COL_W-1:0]};
                mem.wr_data = {attr_reg, BLANK_CODE};
                if (cnt_reg[COL_W-1:0] == COL_W'(COLUMNS - 1))
                begin
                    result_valid_next = 1'b1;
                    result_next = make_res(KIND_ECHO, NEWLINE_CODE, 16'h0,
                                           1'b1, row_reg, col_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            ST_ECHO_NL:
            begin
                // Second echo of a wrapped line
                result_valid_next = 1'b1;
                result_next = make_res(KIND_ECHO, NEWLINE_CODE, 16'h0,
                                       1'b1, row_reg, col_reg);
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            row_reg          <= '0;
            col_reg          <= '0;
            top_reg          <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            top_reg          <= top_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        clr_row_reg <= clr_row_next;
        attr_reg    <= attr_next;
        inrange_reg <= inrange_next;
        result_reg  <= result_next;
    end

    // A plain character always echoes in the following cycle
    a_char_echo: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.req_type == REQ_WRITE) && (req.char_code != NEWLINE_CODE)
        |=> result_valid_reg && (result_reg.result_kind == KIND_ECHO))
        else $error("character write gave no echo");

    // A read returns its cell through the ST_READ state and the result register
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.req_type == REQ_READ)
        |-> ##2 result_valid_reg && (result_reg.result_kind == KIND_CELL))
        else $error("read result missing");

    // Cursor and row base stay inside the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < (COL_W+1)'(COLUMNS)) &&
        ({1'b0, row_reg} < (ROW_W+1)'(ROWS)) &&
        ({1'b0, top_reg} < (ROW_W+1)'(ROWS)))
        else $error("cursor outside screen");

    // A non-final result is always followed by more work on the same request
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.last |-> busy)
        else $error("request ended without its final result");

endmodule

// ===== hw/rtl/text_console_cursor_scroll_top.sv =====
// Top level of the text console engine: attribute register, cell store, sequencer.
// Depends on tcs_pkg, tcs_ram and tcs_ctrl.
//
// Requests are taken when start is high and busy is low. A plain character
// write echoes in the cycle after it is taken; one that wraps the line adds a
// newline echo; a cell read passes through the registered read port of the
// cell store and the ST_READ state. Scrolling rotates a row base instead of
// moving rows, so a scroll only blanks the new bottom row, one cell per cycle.
// After reset all ROWS * 2**ceil(log2(COLUMNS)) cells (3200 at the default
// size) are swept to blank grey, with busy high throughout. Each result
// appears for a single cycle with result_valid high and must be taken then:
// there is no back-pressure on the result side. The attribute register is
// written through cfg_valid/cfg_ready whenever no request is in flight.
module text_console_cursor_scroll_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tcs_pkg::req_t  req,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_data,
    output logic           result_valid,
    output tcs_pkg::res_t  result
);
    import tcs_pkg::*;

    logic [7:0]        text_color_reg;
    mem_req_t          mem;
    logic [CELL_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    // Hold the configured attribute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            text_color_reg <= cfg_data;
        end
    end

    // Cell store
    tcs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MEM_DEPTH)
    ) u_cells (
        .clk     (clk),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_data),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_data)
    );

    // Request sequencer
    tcs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .text_color   (text_color_reg),
        .mem          (mem),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== bench/text_console_cursor_scroll_top_tb.sv =====
// Testbench for text_console_cursor_scroll_top: drives character, newline and cell-read
// requests and checks every echo and cell result against a shadow copy of the screen.
// Depends on tcs_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module text_console_cursor_scroll_top_tb;

    import tcs_pkg::*;

    // Shadow screen, cursor and attribute; turns each request into its due results
    class console_mirror;
        logic [15:0] shadow_cells [ROWS][COLUMNS];
        int unsigned cur_row;
        int unsigned cur_col;
        logic [7:0]  color;
        res_t        due_results[$];
        int unsigned mismatches;

        function new();
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLUMNS; c++)
                    shadow_cells[r][c] = RESET_CELL;
            cur_row    = 0;
            cur_col    = 0;
            color      = RESET_COLOR;
            mismatches = 0;
        endfunction

        // Move to the start of the next line, scrolling up on the bottom row
        function void line_feed(logic [7:0] attr);
            cur_col = 0;
            if (cur_row + 1 >= ROWS)
            begin
                for (int r = 0; r < ROWS - 1; r++)
                    for (int c = 0; c < COLUMNS; c++)
                        shadow_cells[r][c] = shadow_cells[r + 1][c];
                for (int c = 0; c < COLUMNS; c++)
                    shadow_cells[ROWS - 1][c] = {attr, BLANK_CODE};
            end
            else
            begin
                cur_row++;
            end
        endfunction

        // Apply an accepted request and queue the results it must produce
        function void take_request(req_t r);
            logic [7:0] attr;
            res_t       first;
            res_t       second;
            bit         wrapped;
            attr    = r.error_style ? ERROR_ATTR : color;
            first   = '0;
            second  = '0;
            wrapped = 1'b0;
            if (r.req_type == REQ_READ)
            begin
                first.result_kind = KIND_CELL;
                if (r.read_row < ROWS && r.read_col < COLUMNS)
                    first.cell_word = shadow_cells[r.read_row][r.read_col];
            end
            else if (r.char_code == NEWLINE_CODE)
            begin
                line_feed(attr);
                first.result_kind = KIND_ECHO;
                first.serial_byte = r.char_code;
            end
            else
            begin
                shadow_cells[cur_row][cur_col] = {attr, r.char_code};
                cur_col++;
                first.result_kind = KIND_ECHO;
                first.serial_byte = r.char_code;
                if (cur_col >= COLUMNS)
                begin
                    line_feed(attr);
                    wrapped = 1'b1;
                end
            end
            // Stamp the cursor as it stands after the request
            first.cursor_row  = 5'(cur_row);
            first.cursor_col  = 7'(cur_col);
            second.cursor_row = 5'(cur_row);
            second.cursor_col = 7'(cur_col);
            if (wrapped)
            begin
                second.result_kind = KIND_ECHO;
                second.serial_byte = NEWLINE_CODE;
                second.last        = 1'b1;
                due_results.push_back(first);
                due_results.push_back(second);
            end
            else
            begin
                first.last = 1'b1;
                due_results.push_back(first);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare a delivered result with the oldest one due
        function void check_result(res_t got);
            res_t want;
            if (due_results.size() == 0)
            begin
                $error("result with none due: kind %0h byte %0h cell %0h",
                       got.result_kind, got.serial_byte, got.cell_word);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
            compare_field("serial_byte", 16'(want.serial_byte), 16'(got.serial_byte));
            compare_field("cell_word", want.cell_word, got.cell_word);
            compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
            compare_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
            compare_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    logic       result_valid;
    res_t       result;

    console_mirror mirror = new();

    int unsigned idle_pct;
    int unsigned newline_pct;
    int unsigned read_pct;
    int unsigned error_pct;

    text_console_cursor_scroll_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #2 clk = ~clk;

    // Take each strobed result at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
            mirror.check_result(result);
    end

    function automatic req_t make_request(logic kind, logic [7:0] ch, logic err,
                                          logic [4:0] row, logic [6:0] col);
        req_t r;
        r.req_type    = kind;
        r.char_code   = ch;
        r.error_style = err;
        r.read_row    = row;
        r.read_col    = col;
        return r;
    endfunction

    // Build a random request under the current mix of reads, newlines and error style
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        r = make_request(REQ_WRITE, 8'($urandom_range(255)),
                         1'($urandom_range(99) < error_pct),
                         5'($urandom_range(31)), 7'($urandom_range(127)));
        if ($urandom_range(99) < read_pct)
        begin
            r.req_type = REQ_READ;
            pick = $urandom_range(9);
            // Aim most reads at live cells: the cursor row, the bottom row, anywhere
            if (pick < 3)
            begin
                r.read_row = 5'(mirror.cur_row);
                r.read_col = 7'($urandom_range(COLUMNS - 1));
            end
            else if (pick < 5)
            begin
                r.read_row = 5'(ROWS - 1);
                r.read_col = 7'($urandom_range(COLUMNS - 1));
            end
            else if (pick < 8)
            begin
                r.read_row = 5'($urandom_range(ROWS - 1));
                r.read_col = 7'($urandom_range(COLUMNS - 1));
            end
        end
        else if ($urandom_range(99) < newline_pct)
        begin
            r.char_code = NEWLINE_CODE;
        end
        return r;
    endfunction

    // Offer one request after a random gap and hold it until taken
    task automatic send(input req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        mirror.take_request(r);
    endtask

    // Drop start and wait for every due result, the tail of any scroll and busy low
    task automatic settle();
        start <= 1'b0;
        while (mirror.due_results.size() != 0)
            @(posedge clk);
        repeat (COLUMNS + 8) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_color(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        mirror.color = value;
    endtask

    // Walk the cursor to the bottom row, then fill it so that it wraps and scrolls
    task automatic scroll_burst();
        while (mirror.cur_row < ROWS - 1)
            send(make_request(REQ_WRITE, NEWLINE_CODE, 1'($urandom_range(1)),
                              5'($urandom_range(31)), 7'($urandom_range(127))));
        while (mirror.cur_col < COLUMNS - 1)
            send(make_request(REQ_WRITE, 8'($urandom_range(11, 255)), 1'b0,
                              5'($urandom_range(31)), 7'($urandom_range(127))));
        send(make_request(REQ_WRITE, 8'h2A, 1'b1, 5'd0, 7'd0));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'(ROWS - 1), 7'd0));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'(ROWS - 1), 7'(COLUMNS - 1)));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'(ROWS - 2), 7'(COLUMNS - 1)));
    endtask

    initial
    begin
        logic [7:0]  phase_color [4];
        int unsigned phase_idle [4];
        rst_n       <= 1'b0;
        start       <= 1'b0;
        req         <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        idle_pct    = 0;
        newline_pct = 10;
        read_pct    = 30;
        error_pct   = 20;
        phase_color = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255))};
        // Receiver stalls cannot happen here, so the phases vary the sender alone
        phase_idle  = '{0, 81, 13, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: cleared store, out-of-range reads, byte extremes, error style
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'd0, 7'd0));
        send(make_request(REQ_READ, 8'hFF, 1'b1, 5'(ROWS - 1), 7'(COLUMNS - 1)));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'(ROWS), 7'd0));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'd0, 7'(COLUMNS)));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'd31, 7'd127));
        send(make_request(REQ_WRITE, 8'h00, 1'b0, 5'd31, 7'd127));
        send(make_request(REQ_WRITE, 8'hFF, 1'b0, 5'd0, 7'd0));
        send(make_request(REQ_WRITE, 8'h41, 1'b1, 5'd0, 7'd0));
        send(make_request(REQ_WRITE, NEWLINE_CODE, 1'b0, 5'd0, 7'd0));
        send(make_request(REQ_WRITE, NEWLINE_CODE, 1'b1, 5'd0, 7'd0));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'd0, 7'd0));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'd0, 7'd1));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'd0, 7'd2));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'd0, 7'd3));
        send(make_request(REQ_WRITE, 8'h7F, 1'b0, 5'd0, 7'd0));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'd2, 7'd0));
        send(make_request(REQ_READ, 8'h00, 1'b0, 5'd1, 7'd0));

        // Random phases, each under its own attribute and sender gap rate
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            write_color(phase_color[phase]);
            idle_pct = phase_idle[phase];
            scroll_burst();
            for (int i = 0; i < 150; i++)
            begin
                if (i % 100 == 0)
                begin
                    newline_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(3, 30);
                    read_pct    = ($urandom_range(1) == 0) ? 10 : 35;
                    error_pct   = $urandom_range(5, 40);
                end
                // Hold off mid-phase until the block has delivered everything
                if (i == 100 && phase == 1)
                    settle();
                send(random_request());
            end
        end

        settle();
        write_color(RESET_COLOR);
        if (mirror.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Bound the run well beyond the slowest correct one
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
